/* rtl/core/pft_pkg.sv */
// ----------------------------------------------------------------------------
// pft_pkg
// Types, constants and helper functions shared by the pose frame transform.
// ----------------------------------------------------------------------------
package pft_pkg;

   localparam int COORD_W  = 32;             // position width, signed fixed point
   localparam int ANGLE_W  = 16;             // heading width, binary angle units
   localparam int OPND_W   = COORD_W + 1;    // position difference width
   localparam int TRIG_W   = 34;             // cordic x/y datapath width
   localparam int CS_W     = 32;             // sine/cosine width, Q2.30
   localparam int Z_W      = 33;             // cordic residual angle width
   localparam int PROD_W   = OPND_W + CS_W;  // one product
   localparam int SUM_W    = PROD_W + 1;     // sum of two products
   localparam int ROT_W    = SUM_W - 30;     // rounded rotation term
   localparam int WIDE_W   = 40;             // headroom before saturation
   localparam int TAB_LEN  = 24;

   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);
   localparam logic signed [SUM_W-1:0]  ROUND_HALF  = SUM_W'(64'sd536870912);

   typedef enum logic [1:0] {
      ACT_FORWARD  = 2'd0,
      ACT_BACKWARD = 2'd1,
      ACT_SOLVE    = 2'd2,
      ACT_UPDATE   = 2'd3
   } action_type;

   typedef struct packed {
      action_type                 action;
      logic signed [COORD_W-1:0]  pose_x;
      logic signed [COORD_W-1:0]  pose_y;
      logic signed [ANGLE_W-1:0]  pose_angle;
      logic signed [COORD_W-1:0]  local_x;
      logic signed [COORD_W-1:0]  local_y;
      logic signed [ANGLE_W-1:0]  local_angle;
      logic signed [COORD_W-1:0]  corr_x;
      logic signed [COORD_W-1:0]  corr_y;
      logic signed [ANGLE_W-1:0]  corr_angle;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  out_x;
      logic signed [COORD_W-1:0]  out_y;
      logic signed [ANGLE_W-1:0]  out_angle;
   } rsp_type;

   // operands that ride along the cordic stages
   typedef struct packed {
      action_type                 action;
      logic signed [OPND_W-1:0]   a1;
      logic signed [OPND_W-1:0]   b1;
      logic signed [OPND_W-1:0]   a2;
      logic signed [OPND_W-1:0]   b2;
      logic signed [COORD_W-1:0]  k_x;
      logic signed [COORD_W-1:0]  k_y;
      logic signed [COORD_W-1:0]  p_x;
      logic signed [COORD_W-1:0]  p_y;
      logic signed [ANGLE_W-1:0]  angle;
   } ctx_type;

   // arctangent of 2^-i in 32-bit binary angle units
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10680350;
         5'd7:    v = 32'd5340245;
         5'd8:    v = 32'd2670163;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         5'd21:   v = 32'd326;
         5'd22:   v = 32'd163;
         5'd23:   v = 32'd81;
         default: v = 32'd0;
      endcase
      return signed'({1'b0, v});
   endfunction

   // clamp to the signed position range
   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'({1'b0, {(COORD_W-1){1'b1}}});
      lo = -hi - WIDE_W'(1);
      if (v > hi) begin
         return hi[COORD_W-1:0];
      end else if (v < lo) begin
         return lo[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

/* rtl/core/pose_frame_transform.sv */
// ----------------------------------------------------------------------------
// pose_frame_transform
// Pipelined 2D rigid pose composition: forward, backward, solve, update.
// ----------------------------------------------------------------------------
// registers from request to response: stage zero, the cordic stages, trig, products, rounding, combine, output
// throughput: one transaction per cycle unless the response side stalls; two cordic pipes
//   run side by side, one stage per iteration, so nothing is shared between transactions
// a stall on the response side freezes every stage at once
// reset clears all stage valid bits; data registers are not reset
module pose_frame_transform import pft_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int N = CORDIC_STAGES;

   logic adv;

   // global advance: the whole pipe moves unless the output is held
   assign adv       = ~rsp_valid | rsp_ready;
   assign req_ready = adv;

   // ---------------------------------------------------------------- input
   ctx_type                  ctx_in;
   logic [ANGLE_W-1:0]       th1;
   logic [ANGLE_W-1:0]       th2;
   logic signed [COORD_W-1:0] l2_x;
   logic signed [COORD_W-1:0] l2_y;
   logic signed [OPND_W-1:0]  dx;
   logic signed [OPND_W-1:0]  dy;
   logic [31:0]              w1;
   logic [31:0]              w2;
   logic                     neg1_in;
   logic                     neg2_in;

   always_comb begin
      dx   = OPND_W'(req_data.pose_x) - OPND_W'(req_data.corr_x);
      dy   = OPND_W'(req_data.pose_y) - OPND_W'(req_data.corr_y);
      l2_x = sat_coord(WIDE_W'(req_data.local_x) + WIDE_W'(req_data.pose_x));
      l2_y = sat_coord(WIDE_W'(req_data.local_y) + WIDE_W'(req_data.pose_y));
      th1  = req_data.corr_angle;
      th2  = (req_data.action == ACT_SOLVE) ?
             ANGLE_W'(req_data.pose_angle - req_data.local_angle) :
             ANGLE_W'(req_data.corr_angle - req_data.pose_angle);

      ctx_in.action = req_data.action;
      ctx_in.k_x    = req_data.corr_x;
      ctx_in.k_y    = req_data.corr_y;
      ctx_in.p_x    = req_data.pose_x;
      ctx_in.p_y    = req_data.pose_y;
      if (req_data.action == ACT_FORWARD) begin
         ctx_in.a1 = dx;
         ctx_in.b1 = dy;
      end else begin
         ctx_in.a1 = OPND_W'(req_data.local_x);
         ctx_in.b1 = OPND_W'(req_data.local_y);
      end
      if (req_data.action == ACT_UPDATE) begin
         ctx_in.a2 = OPND_W'(l2_x);
         ctx_in.b2 = OPND_W'(l2_y);
      end else begin
         ctx_in.a2 = OPND_W'(req_data.local_x);
         ctx_in.b2 = OPND_W'(req_data.local_y);
      end
      unique case (req_data.action)
         ACT_FORWARD:  ctx_in.angle = req_data.pose_angle - req_data.corr_angle;
         ACT_BACKWARD: ctx_in.angle = req_data.corr_angle + req_data.local_angle;
         ACT_SOLVE:    ctx_in.angle = req_data.pose_angle - req_data.local_angle;
         ACT_UPDATE:   ctx_in.angle = req_data.corr_angle - req_data.pose_angle;
         default:      ctx_in.angle = req_data.pose_angle;
      endcase

      // fold into [-pi/2, pi/2) by a half turn
      w1      = {th1, {(32-ANGLE_W){1'b0}}};
      w2      = {th2, {(32-ANGLE_W){1'b0}}};
      neg1_in = w1[31] ^ w1[30];
      neg2_in = w2[31] ^ w2[30];
      w1[31]  = w1[31] ^ neg1_in;
      w2[31]  = w2[31] ^ neg2_in;
   end

   // ---------------------------------------------------------------- cordic
   logic                     cv_ff   [0:N];
   ctx_type                  cctx_ff [0:N];
   logic                     neg1_ff [0:N];
   logic                     neg2_ff [0:N];
   logic signed [TRIG_W-1:0] x1_ff   [0:N];
   logic signed [TRIG_W-1:0] y1_ff   [0:N];
   logic signed [Z_W-1:0]    z1_ff   [0:N];
   logic signed [TRIG_W-1:0] x2_ff   [0:N];
   logic signed [TRIG_W-1:0] y2_ff   [0:N];
   logic signed [Z_W-1:0]    z2_ff   [0:N];

   // stage zero takes the folded start vectors
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cctx_ff[0] <= ctx_in;
         neg1_ff[0] <= neg1_in;
         neg2_ff[0] <= neg2_in;
         x1_ff[0]   <= CORDIC_GAIN;
         y1_ff[0]   <= '0;
         z1_ff[0]   <= signed'({w1[31], w1});
         x2_ff[0]   <= CORDIC_GAIN;
         y2_ff[0]   <= '0;
         z2_ff[0]   <= signed'({w2[31], w2});
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic signed [Z_W-1:0] ATAN = atan_entry(5'(i));

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cctx_ff[i+1] <= cctx_ff[i];
            neg1_ff[i+1] <= neg1_ff[i];
            neg2_ff[i+1] <= neg2_ff[i];
            if (!z1_ff[i][Z_W-1]) begin
               x1_ff[i+1] <= x1_ff[i] - (y1_ff[i] >>> i);
               y1_ff[i+1] <= y1_ff[i] + (x1_ff[i] >>> i);
               z1_ff[i+1] <= z1_ff[i] - ATAN;
            end else begin
               x1_ff[i+1] <= x1_ff[i] + (y1_ff[i] >>> i);
               y1_ff[i+1] <= y1_ff[i] - (x1_ff[i] >>> i);
               z1_ff[i+1] <= z1_ff[i] + ATAN;
            end
            if (!z2_ff[i][Z_W-1]) begin
               x2_ff[i+1] <= x2_ff[i] - (y2_ff[i] >>> i);
               y2_ff[i+1] <= y2_ff[i] + (x2_ff[i] >>> i);
               z2_ff[i+1] <= z2_ff[i] - ATAN;
            end else begin
               x2_ff[i+1] <= x2_ff[i] + (y2_ff[i] >>> i);
               y2_ff[i+1] <= y2_ff[i] - (x2_ff[i] >>> i);
               z2_ff[i+1] <= z2_ff[i] + ATAN;
            end
         end
      end
   end

   // ---------------------------------------------------------------- trig
   logic                     tv_ff;
   ctx_type                  tctx_ff;
   logic signed [CS_W-1:0]   c1_ff, s1_ff, c2_ff, s2_ff;
   logic signed [TRIG_W-1:0] c1_in, s1_in, c2_in, s2_in;

   // undo the fold; forward rotates by the negative angle
   always_comb begin
      c1_in = neg1_ff[N] ? -x1_ff[N] : x1_ff[N];
      s1_in = neg1_ff[N] ? -y1_ff[N] : y1_ff[N];
      c2_in = neg2_ff[N] ? -x2_ff[N] : x2_ff[N];
      s2_in = neg2_ff[N] ? -y2_ff[N] : y2_ff[N];
      if (cctx_ff[N].action == ACT_FORWARD) begin
         s1_in = -s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
      end else if (adv) begin
         tv_ff <= cv_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tctx_ff <= cctx_ff[N];
         c1_ff   <= c1_in[CS_W-1:0];
         s1_ff   <= s1_in[CS_W-1:0];
         c2_ff   <= c2_in[CS_W-1:0];
         s2_ff   <= s2_in[CS_W-1:0];
      end
   end

   // ---------------------------------------------------------------- products
   logic                     mv_ff;
   ctx_type                  mctx_ff;
   logic signed [PROD_W-1:0] p1xa_ff, p1xb_ff, p1ya_ff, p1yb_ff;
   logic signed [PROD_W-1:0] p2xa_ff, p2xb_ff, p2ya_ff, p2yb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
      end else if (adv) begin
         mv_ff <= tv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mctx_ff <= tctx_ff;
         p1xa_ff <= tctx_ff.a1 * c1_ff;
         p1xb_ff <= tctx_ff.b1 * s1_ff;
         p1ya_ff <= tctx_ff.b1 * c1_ff;
         p1yb_ff <= tctx_ff.a1 * s1_ff;
         p2xa_ff <= tctx_ff.a2 * c2_ff;
         p2xb_ff <= tctx_ff.b2 * s2_ff;
         p2ya_ff <= tctx_ff.b2 * c2_ff;
         p2yb_ff <= tctx_ff.a2 * s2_ff;
      end
   end

   // ---------------------------------------------------------------- rounding
   logic                    rv_ff;
   ctx_type                 rctx_ff;
   logic signed [ROT_W-1:0] r1x_ff, r1y_ff, r2x_ff, r2y_ff;
   logic signed [SUM_W-1:0] sum1x, sum1y, sum2x, sum2y;

   // round to nearest, ties toward plus infinity
   always_comb begin
      sum1x = SUM_W'(p1xa_ff) - SUM_W'(p1xb_ff) + ROUND_HALF;
      sum1y = SUM_W'(p1ya_ff) + SUM_W'(p1yb_ff) + ROUND_HALF;
      sum2x = SUM_W'(p2xa_ff) - SUM_W'(p2xb_ff) + ROUND_HALF;
      sum2y = SUM_W'(p2ya_ff) + SUM_W'(p2yb_ff) + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (adv) begin
         rv_ff <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rctx_ff <= mctx_ff;
         r1x_ff  <= sum1x[SUM_W-1:30];
         r1y_ff  <= sum1y[SUM_W-1:30];
         r2x_ff  <= sum2x[SUM_W-1:30];
         r2y_ff  <= sum2y[SUM_W-1:30];
      end
   end

   // ---------------------------------------------------------------- combine
   logic                      bv_ff;
   logic                      bsub_ff;
   logic signed [COORD_W-1:0] base_x_ff, base_y_ff;
   logic signed [ROT_W-1:0]   b2x_ff, b2y_ff;
   logic signed [ANGLE_W-1:0] bang_ff;
   logic signed [COORD_W-1:0] base_x_in, base_y_in;

   // forward: rotated difference; solve: pose; backward and update: corr plus rotation
   always_comb begin
      unique case (rctx_ff.action)
         ACT_FORWARD: begin
            base_x_in = sat_coord(WIDE_W'(r1x_ff));
            base_y_in = sat_coord(WIDE_W'(r1y_ff));
         end
         ACT_SOLVE: begin
            base_x_in = rctx_ff.p_x;
            base_y_in = rctx_ff.p_y;
         end
         default: begin
            base_x_in = sat_coord(WIDE_W'(rctx_ff.k_x) + WIDE_W'(r1x_ff));
            base_y_in = sat_coord(WIDE_W'(rctx_ff.k_y) + WIDE_W'(r1y_ff));
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= 1'b0;
      end else if (adv) begin
         bv_ff <= rv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         base_x_ff <= base_x_in;
         base_y_ff <= base_y_in;
         b2x_ff    <= r2x_ff;
         b2y_ff    <= r2y_ff;
         bang_ff   <= rctx_ff.angle;
         bsub_ff   <= (rctx_ff.action == ACT_SOLVE) || (rctx_ff.action == ACT_UPDATE);
      end
   end

   // ---------------------------------------------------------------- output
   logic    ov_ff;
   rsp_type out_ff;
   rsp_type out_in;

   // solve and update: subtract the second rotation from the base pose
   always_comb begin
      out_in.out_angle = bang_ff;
      if (bsub_ff) begin
         out_in.out_x = sat_coord(WIDE_W'(base_x_ff) - WIDE_W'(b2x_ff));
         out_in.out_y = sat_coord(WIDE_W'(base_y_ff) - WIDE_W'(b2y_ff));
      end else begin
         out_in.out_x = base_x_ff;
         out_in.out_y = base_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= bv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   // ---------------------------------------------------------------- checks
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(c1_ff) && $stable(base_x_ff) && $stable(mv_ff))
      else $error("inner stage moved during a stall");

   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      tv_ff |-> (c1_ff < 32'sh4800_0000) && (c1_ff > -32'sh4800_0000)
             && (c2_ff < 32'sh4800_0000) && (c2_ff > -32'sh4800_0000))
      else $error("cordic cosine out of range");

endmodule
